// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the command builder modules.
// Both macros expect a clock named i_clk; SDCB_ASSERT also expects an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SDCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SDCB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== hdl/sdcb_pkg.sv =====
package sdcb_pkg;

    localparam int SLOT_W  = 5;
    localparam int SCNT_W  = 6;
    localparam int ENT_W   = 4;
    localparam int STEP_W  = 3;
    localparam int KIND_W  = 3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_HDR     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PRD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIS     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_SLOT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD_CNT = 3'd4;

    // ATA opcodes placed in the H2D FIS.
    localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;
    localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;

    // Largest entry count one request may use.
    localparam int ENTRY_CAP = 8;

    // Microprogram step addresses.
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_COUNT  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_HDR    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_PRD    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FIS    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_E_SLOT = 3'd6;
    localparam logic [STEP_W-1:0] STEP_E_CNT  = 3'd7;

    // Register addresses of the configuration port.
    localparam logic [2:0] ADDR_SLOT_COUNT = 3'd0;

    // Jump conditions of a microword; the jump is taken when the condition holds.
    typedef enum logic [2:0] {
        COND_NEXT      = 3'd0,
        COND_GOTO      = 3'd1,
        COND_NO_INPUT  = 3'd2,
        COND_NO_SLOT   = 3'd3,
        COND_BAD_CNT   = 3'd4,
        COND_MORE_PRD  = 3'd5
    } t_cond;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              ld_req;
        logic              ld_slot;
        logic              ld_nent;
        logic              prd_adv;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Control from the sequencer to the datapath, already qualified.
    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              ld_req;
        logic              ld_slot;
        logic              ld_nent;
        logic              prd_adv;
    } t_ctl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic out_free;
        logic no_slot;
        logic bad_cnt;
        logic more_prd;
    } t_flags;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  port_index;
        logic [31:0] lba_low;
        logic [15:0] lba_high;
        logic [15:0] sector_count;
        logic [31:0] buffer_addr;
        logic [31:0] busy_slots;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [4:0]        port_number;
        logic [SLOT_W-1:0] slot;
        logic              is_write;
        logic [ENT_W-1:0]  prd_entries;
        logic [31:0]       data_addr;
        logic [12:0]       byte_count_minus1;
        logic              irq_on_done;
        logic [7:0]        ata_command;
        logic [47:0]       fis_lba;
        logic [15:0]       fis_count;
        logic              last;
    } t_out_item;

endpackage

// ===== hdl/sata_dma_command_builder.sv =====
// SATA DMA command builder.
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat is one request
// (read or write, port, 48-bit LBA, sector count, buffer address, busy slots).
// Output channel (o_out_valid / i_out_stall / o_out_data): a request yields a
// header beat, one PRD beat per group of SECTORS_PER_ENTRY sectors and a FIS
// beat carrying the issue slot, or a single error beat when no slot is free or
// the sector count is zero or too large. The final beat carries last.
// The APB port holds slot_count at address 0; write it only while idle.
// A microprogram of eight steps sequences the work: one step to search for a
// slot, one to size the PRD table, then one result beat per step. After
// acceptance the program passes the slot check and the sizing step before the
// header step loads the first result beat into the output register.
// Requests are taken one at a time, only while the program sits in its idle step.
// When the receiver stalls, the output register holds its beat and the
// program waits at its emitting step. Synchronous reset returns the program
// to idle, drops the output beat and sets slot_count to 32.
module sata_dma_command_builder #(
    parameter int MAX_PRD_ENTRIES   = 8,
    parameter int SECTORS_PER_ENTRY = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sdcb_pkg::t_in_item    i_in_data,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sdcb_pkg::t_out_item   o_out_data,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Number of slots offered for search; values above 32 act as 32.
    logic [sdcb_pkg::SCNT_W-1:0] r_slot_count;
    sdcb_pkg::t_ctl              ctl;
    sdcb_pkg::t_flags            flags;

    // The port never inserts wait states.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= 6'd32;
        end else if (psel && penable && pwrite && (paddr == sdcb_pkg::ADDR_SLOT_COUNT)) begin
            r_slot_count <= pwdata[sdcb_pkg::SCNT_W-1:0];
        end
    end

    // Reads of unused addresses return zero.
    assign prdata = (paddr == sdcb_pkg::ADDR_SLOT_COUNT) ? {26'd0, r_slot_count} : 32'd0;

    // The sequencer owns the step counter and control store; it tells the
    // datapath when to capture a request, latch the slot, size the PRD table
    // and push a result beat into the output register.
    sdcb_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the request, the slot search, the entry stepping
    // and the output register that parts the block from the receiver.
    sdcb_datapath #(
        .MAX_PRD_ENTRIES   (MAX_PRD_ENTRIES),
        .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_count (r_slot_count),
        .i_in_data    (i_in_data),
        .i_ctl        (ctl),
        .o_flags      (flags),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== hdl/sdcb_sequencer.sv =====
`include "assert_macros.svh"

module sdcb_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sdcb_pkg::t_flags  i_flags,
    output sdcb_pkg::t_ctl    o_ctl,
    output logic              o_in_stall
);

    // The control store: one microword per step.
    function automatic sdcb_pkg::t_uword rom(input logic [sdcb_pkg::STEP_W-1:0] addr);
        sdcb_pkg::t_uword w;
        w = '0;
        w.cond = sdcb_pkg::COND_NEXT;
        case (addr)
            sdcb_pkg::STEP_IDLE: begin
                w.ld_req = 1'b1;
                w.cond   = sdcb_pkg::COND_NO_INPUT;
                w.target = sdcb_pkg::STEP_IDLE;
            end
            sdcb_pkg::STEP_CHECK: begin
                w.ld_slot = 1'b1;
                w.cond    = sdcb_pkg::COND_NO_SLOT;
                w.target  = sdcb_pkg::STEP_E_SLOT;
            end
            sdcb_pkg::STEP_COUNT: begin
                w.ld_nent = 1'b1;
                w.cond    = sdcb_pkg::COND_BAD_CNT;
                w.target  = sdcb_pkg::STEP_E_CNT;
            end
            sdcb_pkg::STEP_HDR: begin
                w.emit = 1'b1;
                w.kind = sdcb_pkg::KIND_HDR;
            end
            sdcb_pkg::STEP_PRD: begin
                w.emit    = 1'b1;
                w.kind    = sdcb_pkg::KIND_PRD;
                w.prd_adv = 1'b1;
                w.cond    = sdcb_pkg::COND_MORE_PRD;
                w.target  = sdcb_pkg::STEP_PRD;
            end
            sdcb_pkg::STEP_FIS: begin
                w.emit   = 1'b1;
                w.kind   = sdcb_pkg::KIND_FIS;
                w.last   = 1'b1;
                w.cond   = sdcb_pkg::COND_GOTO;
                w.target = sdcb_pkg::STEP_IDLE;
            end
            sdcb_pkg::STEP_E_SLOT: begin
                w.emit   = 1'b1;
                w.kind   = sdcb_pkg::KIND_NO_SLOT;
                w.last   = 1'b1;
                w.cond   = sdcb_pkg::COND_GOTO;
                w.target = sdcb_pkg::STEP_IDLE;
            end
            sdcb_pkg::STEP_E_CNT: begin
                w.emit   = 1'b1;
                w.kind   = sdcb_pkg::KIND_BAD_CNT;
                w.last   = 1'b1;
                w.cond   = sdcb_pkg::COND_GOTO;
                w.target = sdcb_pkg::STEP_IDLE;
            end
            default: begin
                w.cond   = sdcb_pkg::COND_GOTO;
                w.target = sdcb_pkg::STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [sdcb_pkg::STEP_W-1:0] r_step;
    logic [sdcb_pkg::STEP_W-1:0] n_step;
    sdcb_pkg::t_uword            uw;
    logic                        advance;
    logic                        take_jump;

    assign uw      = rom(r_step);
    assign advance = !uw.emit || i_flags.out_free;

    always_comb begin
        case (uw.cond)
            sdcb_pkg::COND_NEXT:     take_jump = 1'b0;
            sdcb_pkg::COND_GOTO:     take_jump = 1'b1;
            sdcb_pkg::COND_NO_INPUT: take_jump = !i_in_valid;
            sdcb_pkg::COND_NO_SLOT:  take_jump = i_flags.no_slot;
            sdcb_pkg::COND_BAD_CNT:  take_jump = i_flags.bad_cnt;
            sdcb_pkg::COND_MORE_PRD: take_jump = i_flags.more_prd;
            default:                 take_jump = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (advance) begin
            n_step = take_jump ? uw.target : r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sdcb_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_ctl.emit    = uw.emit && i_flags.out_free;
        o_ctl.kind    = uw.kind;
        o_ctl.last    = uw.last;
        o_ctl.ld_req  = uw.ld_req && i_in_valid;
        o_ctl.ld_slot = uw.ld_slot;
        o_ctl.ld_nent = uw.ld_nent;
        o_ctl.prd_adv = uw.prd_adv && i_flags.out_free;
    end

    // Requests are taken only at the top of the program.
    assign o_in_stall = !uw.ld_req;

    `SDCB_ASSERT_ALWAYS(a_reset_to_idle, !i_rst_n |=> r_step == sdcb_pkg::STEP_IDLE, "program did not restart at reset")
    `SDCB_ASSERT(a_accept_to_check, (r_step == sdcb_pkg::STEP_IDLE && i_in_valid) |=> r_step == sdcb_pkg::STEP_CHECK, "accepted request did not start the slot check")

endmodule

// ===== hdl/sdcb_datapath.sv =====
`include "assert_macros.svh"

module sdcb_datapath #(
    parameter int MAX_PRD_ENTRIES   = 8,
    parameter int SECTORS_PER_ENTRY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sdcb_pkg::SCNT_W-1:0]   i_slot_count,
    input  sdcb_pkg::t_in_item            i_in_data,
    input  sdcb_pkg::t_ctl                i_ctl,
    output sdcb_pkg::t_flags              o_flags,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output sdcb_pkg::t_out_item           o_out_data
);

    localparam int          LIMIT     = (MAX_PRD_ENTRIES > sdcb_pkg::ENTRY_CAP) ?
                                        sdcb_pkg::ENTRY_CAP : MAX_PRD_ENTRIES;
    localparam logic [31:0] ADDR_STEP = 32'(SECTORS_PER_ENTRY * 512);
    localparam logic [15:0] SPE       = 16'(SECTORS_PER_ENTRY);
    localparam logic [16:0] MAX_SECS  = 17'(LIMIT * SECTORS_PER_ENTRY);

    sdcb_pkg::t_in_item             r_req;
    logic [sdcb_pkg::SLOT_W-1:0]    r_slot;
    logic [sdcb_pkg::ENT_W-1:0]     r_nent;
    logic [sdcb_pkg::ENT_W-1:0]     r_ent_idx;
    logic [15:0]                    r_rem;
    logic [31:0]                    r_addr;
    logic                           r_out_valid;
    sdcb_pkg::t_out_item            r_out;

    logic [sdcb_pkg::SCNT_W-1:0]    lim_slots;
    logic [31:0]                    free_mask;
    logic [sdcb_pkg::SLOT_W-1:0]    first_free;
    logic [sdcb_pkg::ENT_W-1:0]     nent_calc;
    logic                           bad_cnt;
    logic                           last_ent;
    logic [15:0]                    secs;
    logic [15:0]                    secs_m1;
    logic                           out_free;
    sdcb_pkg::t_out_item            payload;

    // Slot search: lowest clear busy bit among the offered slots.
    assign lim_slots = (i_slot_count > 6'd32) ? 6'd32 : i_slot_count;

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            free_mask[i] = !r_req.busy_slots[i] && (6'(i) < lim_slots);
        end
        first_free = '0;
        for (int i = 31; i >= 0; i--) begin
            if (free_mask[i]) begin
                first_free = 5'(i);
            end
        end
    end

    // Entry count is the number of entry boundaries that lie below the count.
    always_comb begin
        nent_calc = '0;
        for (int k = 0; k < LIMIT; k++) begin
            nent_calc = nent_calc + {3'd0, ({1'b0, r_req.sector_count} >
                                            17'(k * SECTORS_PER_ENTRY))};
        end
    end

    assign bad_cnt  = (r_req.sector_count == 16'd0) ||
                      ({1'b0, r_req.sector_count} > MAX_SECS);
    assign last_ent = (4'(r_ent_idx + 4'd1) == r_nent);
    assign secs     = last_ent ? r_rem : SPE;
    assign secs_m1  = secs - 16'd1;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_flags.out_free = out_free;
        o_flags.no_slot  = !(|free_mask);
        o_flags.bad_cnt  = bad_cnt;
        o_flags.more_prd = !last_ent;
    end

    always_comb begin
        payload             = '0;
        payload.kind        = i_ctl.kind;
        payload.port_number = r_req.port_index;
        payload.last        = i_ctl.last;
        case (i_ctl.kind)
            sdcb_pkg::KIND_HDR: begin
                payload.slot        = r_slot;
                payload.is_write    = r_req.cmd;
                payload.prd_entries = r_nent;
            end
            sdcb_pkg::KIND_PRD: begin
                payload.slot              = r_slot;
                payload.is_write          = r_req.cmd;
                payload.prd_entries       = r_nent;
                payload.data_addr         = r_addr;
                payload.byte_count_minus1 = {secs_m1[3:0], 9'h1FF};
                payload.irq_on_done       = !r_req.cmd;
            end
            sdcb_pkg::KIND_FIS: begin
                payload.slot        = r_slot;
                payload.is_write    = r_req.cmd;
                payload.prd_entries = r_nent;
                payload.ata_command = r_req.cmd ? sdcb_pkg::ATA_WRITE_DMA_EXT :
                                                  sdcb_pkg::ATA_READ_DMA_EXT;
                payload.fis_lba     = {r_req.lba_high, r_req.lba_low};
                payload.fis_count   = r_req.sector_count;
            end
            default: begin
                payload.kind = i_ctl.kind;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_req) begin
            r_req <= i_in_data;
        end
        if (i_ctl.ld_slot) begin
            r_slot <= first_free;
        end
        if (i_ctl.ld_nent) begin
            r_nent    <= nent_calc;
            r_ent_idx <= '0;
            r_rem     <= r_req.sector_count;
            r_addr    <= r_req.buffer_addr;
        end else if (i_ctl.prd_adv) begin
            r_ent_idx <= 4'(r_ent_idx + 4'd1);
            r_rem     <= r_rem - SPE;
            r_addr    <= r_addr + ADDR_STEP;
        end
        if (i_ctl.emit) begin
            r_out <= payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SDCB_ASSERT(a_prd_has_sectors, (i_ctl.emit && i_ctl.kind == sdcb_pkg::KIND_PRD) |-> (r_rem != 16'd0 && r_ent_idx < r_nent), "PRD entry emitted past the end of the request")
    `SDCB_ASSERT(a_last_kind, (r_out_valid && r_out.last) |-> (r_out.kind == sdcb_pkg::KIND_FIS || r_out.kind == sdcb_pkg::KIND_NO_SLOT || r_out.kind == sdcb_pkg::KIND_BAD_CNT), "last flag on a non-final result")
    `SDCB_ASSERT(a_no_overwrite, (r_out_valid && i_out_stall) |-> !i_ctl.emit, "stalled result overwritten")

endmodule

// ===== bench/tb_sata_dma_command_builder.sv =====
module tb_sata_dma_command_builder;

    // The block is built with its default table geometry. The bench keeps its own
    // copy so that the predictor does not depend on the instance.
    localparam int PRD_CAP         = 8;
    localparam int SECTORS_PER_PRD = 16;
    localparam int ENTRY_LIMIT     = (PRD_CAP > sdcb_pkg::ENTRY_CAP) ? sdcb_pkg::ENTRY_CAP
                                                                      : PRD_CAP;
    localparam int MAX_SECTORS     = ENTRY_LIMIT * SECTORS_PER_PRD;
    localparam int PRD_BYTES       = SECTORS_PER_PRD * 512;

    // Request direction bit.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Quiet cycles after the last result beat that leave the sequencer parked in idle.
    localparam int DRAIN_CYCLES = 20;
    // Length of the long output hold-off used to back the block up.
    localparam int HOLD_CYCLES  = 300;
    // Watchdog limit, far above the slowest legal run of this bench.
    localparam int CYCLE_LIMIT  = 400000;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    sdcb_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    sdcb_pkg::t_out_item o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Result beats still owed by the block, oldest first.
    sdcb_pkg::t_out_item expected_beats[$];
    // Our copy of the slot_count register.
    logic [5:0]  slot_count_cfg = 6'd32;
    int          error_count    = 0;

    // Idling knobs, in percent of cycles. The test tasks change them per phase.
    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;

    // Long output hold-off: a test bumps hold_seq, the hold process below
    // notices the change and counts the stretch down on its own.
    int unsigned hold_seq    = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;

    sata_dma_command_builder #(
        .MAX_PRD_ENTRIES   (PRD_CAP),
        .SECTORS_PER_ENTRY (SECTORS_PER_PRD)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog. If the run has not ended by now, something is hung.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Works out every result beat that one accepted request must produce and
    // queues them in order: header, one PRD entry per group of sectors, then
    // the FIS beat. Requests that cannot be built give a single error beat.
    function automatic void build_command_beats(input sdcb_pkg::t_in_item req);
        sdcb_pkg::t_out_item beat;
        int unsigned search_lim;
        int unsigned nent;
        int unsigned secs;
        int          free_slot;
        int          s;
        search_lim = (slot_count_cfg > 6'd32) ? 32 : int'(slot_count_cfg);
        free_slot  = -1;
        for (s = 0; s < int'(search_lim); s++) begin
            if (!req.busy_slots[s] && free_slot < 0) free_slot = s;
        end

        beat             = '0;
        beat.port_number = req.port_index;
        beat.last        = 1'b1;

        // The slot search comes first, so a full window wins over a bad count.
        if (free_slot < 0) begin
            beat.kind = sdcb_pkg::KIND_NO_SLOT;
            expected_beats.push_back(beat);
            return;
        end
        nent = (req.sector_count == 16'd0) ? 0
             : (int'(req.sector_count) - 1) / SECTORS_PER_PRD + 1;
        if (nent == 0 || nent > ENTRY_LIMIT) begin
            beat.kind = sdcb_pkg::KIND_BAD_CNT;
            expected_beats.push_back(beat);
            return;
        end

        beat.slot        = free_slot[sdcb_pkg::SLOT_W-1:0];
        beat.is_write    = req.cmd;
        beat.prd_entries = nent[sdcb_pkg::ENT_W-1:0];
        beat.last        = 1'b0;
        beat.kind        = sdcb_pkg::KIND_HDR;
        expected_beats.push_back(beat);

        // Each PRD entry steps the buffer by a full entry; addresses wrap at 4G.
        // Only the final entry may be short. Reads ask for an interrupt.
        for (s = 0; s < int'(nent); s++) begin
            secs = (s + 1 < int'(nent)) ? SECTORS_PER_PRD
                 : int'(req.sector_count) - s * SECTORS_PER_PRD;
            beat.kind              = sdcb_pkg::KIND_PRD;
            beat.data_addr         = req.buffer_addr + 32'(s * PRD_BYTES);
            beat.byte_count_minus1 = 13'(secs * 512 - 1);
            beat.irq_on_done       = ~req.cmd;
            expected_beats.push_back(beat);
        end

        beat.kind              = sdcb_pkg::KIND_FIS;
        beat.data_addr         = '0;
        beat.byte_count_minus1 = '0;
        beat.irq_on_done       = 1'b0;
        beat.ata_command       = (req.cmd == CMD_WRITE) ? sdcb_pkg::ATA_WRITE_DMA_EXT
                                                        : sdcb_pkg::ATA_READ_DMA_EXT;
        beat.fis_lba           = {req.lba_high, req.lba_low};
        beat.fis_count         = req.sector_count;
        beat.last              = 1'b1;
        expected_beats.push_back(beat);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and output back-pressure
    // ------------------------------------------------------------------

    function automatic string differing_fields(input sdcb_pkg::t_out_item e,
                                               input sdcb_pkg::t_out_item g);
        string names;
        names = "";
        if (e.kind !== g.kind)                           names = {names, " kind"};
        if (e.port_number !== g.port_number)             names = {names, " port_number"};
        if (e.slot !== g.slot)                           names = {names, " slot"};
        if (e.is_write !== g.is_write)                   names = {names, " is_write"};
        if (e.prd_entries !== g.prd_entries)             names = {names, " prd_entries"};
        if (e.data_addr !== g.data_addr)                 names = {names, " data_addr"};
        if (e.byte_count_minus1 !== g.byte_count_minus1) names = {names, " byte_count_minus1"};
        if (e.irq_on_done !== g.irq_on_done)             names = {names, " irq_on_done"};
        if (e.ata_command !== g.ata_command)             names = {names, " ata_command"};
        if (e.fis_lba !== g.fis_lba)                     names = {names, " fis_lba"};
        if (e.fis_count !== g.fis_count)                 names = {names, " fis_count"};
        if (e.last !== g.last)                           names = {names, " last"};
        return names;
    endfunction

    task automatic check_beat(input sdcb_pkg::t_out_item got);
        sdcb_pkg::t_out_item want;
        if (expected_beats.size() == 0) begin
            if (error_count < 10) $display("unexpected result beat %h", got);
            error_count++;
        end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
                if (error_count < 10) begin
                    $display("result beat mismatch in%s: expected %h, got %h",
                             differing_fields(want, got), want, got);
                end
                error_count++;
            end
        end
    endtask

    // A beat moves at an edge where valid is high and our stall is low. Both are
    // read here before the edge takes effect; the stall for the next cycle is
    // then chosen from the phase's stall rate and any running hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_beat(o_out_data);
        i_out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_seq != hold_served) begin
            hold_served <= hold_seq;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one request and returns at the edge that accepts it. The sender may
    // first sit idle for some cycles. Valid stays high on return so that
    // back-to-back requests see no bubble; whoever stops sending drops it.
    task automatic send_request(input sdcb_pkg::t_in_item req);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        build_command_beats(req);
    endtask

    // Stops offering, waits for every owed beat and lets the sequencer settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic sdcb_pkg::t_in_item make_request(input logic cmd,
                                                        input logic [4:0] port,
                                                        input logic [47:0] lba,
                                                        input logic [15:0] count,
                                                        input logic [31:0] buffer,
                                                        input logic [31:0] busy);
        sdcb_pkg::t_in_item req;
        req.cmd          = cmd;
        req.port_index   = port;
        req.lba_low      = lba[31:0];
        req.lba_high     = lba[47:32];
        req.sector_count = count;
        req.buffer_addr  = buffer;
        req.busy_slots   = busy;
        return req;
    endfunction

    // Well-formed requests put the lowest free slot inside the search window
    // and ask for a count the PRD table can hold, so they go all the way
    // through header, PRD entries and FIS. The rest is noise: full or random
    // busy masks, zero counts, counts too large and some counts that fit.
    function automatic sdcb_pkg::t_in_item random_request(input bit well_formed);
        sdcb_pkg::t_in_item req;
        int unsigned lim;
        int unsigned k;
        logic [31:0] below;
        lim = (slot_count_cfg > 6'd32) ? 32 : int'(slot_count_cfg);
        req.cmd         = 1'($urandom_range(0, 1));
        req.port_index  = 5'($urandom_range(0, 31));
        req.lba_low     = $urandom;
        req.lba_high    = 16'($urandom_range(0, 16'hFFFF));
        req.buffer_addr = $urandom;
        if (well_formed && lim != 0) begin
            k     = $urandom_range(0, lim - 1);
            below = (32'h1 << k) - 32'h1;
            req.busy_slots   = ($urandom & ~below & ~(32'h1 << k)) | below;
            req.sector_count = 16'($urandom_range(1, MAX_SECTORS));
        end else begin
            req.busy_slots = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
            case ($urandom_range(0, 3))
                0:       req.sector_count = 16'd0;
                1:       req.sector_count = 16'($urandom_range(0, 16'hFFFF));
                2:       req.sector_count = 16'($urandom_range(MAX_SECTORS + 1, 300));
                default: req.sector_count = 16'($urandom_range(1, MAX_SECTORS));
            endcase
        end
        return req;
    endfunction

    task automatic send_random_burst(input int n, input int unsigned noise_pct);
        int i;
        for (i = 0; i < n; i++) begin
            send_request(random_request($urandom_range(0, 99) >= noise_pct));
        end
    endtask

    // Writes slot_count over the APB port while the block is idle, then reads it
    // back. Each transfer is a setup phase followed by an access phase.
    task automatic write_slot_count(input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sdcb_pkg::ADDR_SLOT_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        slot_count_cfg = value[5:0];

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {26'd0, slot_count_cfg}) begin
            if (error_count < 10) begin
                $display("slot_count readback: expected %h, got %h",
                         {26'd0, slot_count_cfg}, prdata);
            end
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked requests at the edges of every field, with no idling.
    task automatic test_directed_cases();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        // Single short entry, slot 0.
        send_request(make_request(CMD_READ, 5'd0, 48'h0, 16'd1, 32'h0, 32'h0));
        // Exactly one full entry; all-ones port, LBA and buffer.
        send_request(make_request(CMD_WRITE, 5'd31, 48'hFFFF_FFFF_FFFF, 16'd16,
                                  32'hFFFF_FFFF, 32'h0));
        // One sector past a full entry spills into a second entry.
        send_request(make_request(CMD_READ, 5'd7, 48'h0001_2345_6789, 16'd17,
                                  32'h1000_0000, 32'h5555_5555));
        // Largest table, with the buffer address wrapping past 4G.
        send_request(make_request(CMD_WRITE, 5'd3, 48'hFFFF_0000_0000, 16'd128,
                                  32'hFFFF_C000, 32'hAAAA_AAAA));
        send_request(make_request(CMD_READ, 5'd12, 48'h0000_FFFF_FFFF, 16'd127,
                                  32'h8000_0200, 32'h0000_00FF));
        // Counts the table cannot hold: zero, one too many, the largest.
        send_request(make_request(CMD_READ, 5'd1, 48'h0, 16'd129, 32'h0, 32'h0));
        send_request(make_request(CMD_WRITE, 5'd2, 48'h0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(CMD_READ, 5'd30, 48'h0, 16'hFFFF, 32'h0, 32'h0));
        // Every slot busy, including together with a zero count.
        send_request(make_request(CMD_WRITE, 5'd9, 48'h1, 16'd8, 32'h400,
                                  32'hFFFF_FFFF));
        send_request(make_request(CMD_READ, 5'd10, 48'h1, 16'd0, 32'h400,
                                  32'hFFFF_FFFF));
        // Only one slot is free: the top slot, then slot 0, then slot 1.
        send_request(make_request(CMD_WRITE, 5'd17, 48'h8000_0000_0001, 16'd33,
                                  32'h0000_1000, 32'h7FFF_FFFF));
        send_request(make_request(CMD_READ, 5'd31, 48'h0, 16'd112, 32'h0, 32'hFFFF_FFFE));
        send_request(make_request(CMD_READ, 5'd5, 48'h0, 16'd113, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFD));
        wait_idle();
    endtask

    // Walks slot_count through its extremes and some values in between. Each
    // setting gets requests whose window is exactly full and requests whose
    // only free slot sits at the window's top, then random ones.
    task automatic test_slot_count_settings();
        logic [31:0] settings[8];
        logic [31:0] window;
        int unsigned lim;
        int          i;
        settings = '{32'd1, 32'd0, 32'd63, 32'd33, 32'd2, 32'd31, 32'hFFFF_FFC5, 32'd32};
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        for (i = 0; i < 8; i++) begin
            write_slot_count(settings[i]);
            lim    = (slot_count_cfg > 6'd32) ? 32 : int'(slot_count_cfg);
            window = (lim >= 32) ? 32'hFFFF_FFFF : (32'h1 << lim) - 32'h1;
            send_request(make_request(CMD_READ, 5'($urandom_range(0, 31)), 48'h0,
                                      16'd20, $urandom, window));
            if (lim != 0) begin
                send_request(make_request(CMD_WRITE, 5'($urandom_range(0, 31)), 48'h0,
                                          16'd40, $urandom,
                                          window & ~(32'h1 << (lim - 1))));
            end
            send_random_burst(4, 20);
        end
    endtask

    // Bulk random traffic under each idling pattern.
    task automatic test_random_phases();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        send_random_burst(90, 20);
        snd_idle_pct  = 75;
        send_random_burst(90, 20);
        snd_idle_pct  = 0;
        rcv_stall_pct = 75;
        send_random_burst(90, 20);
        snd_idle_pct  = 8;
        rcv_stall_pct = 8;
        send_random_burst(90, 20);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the output register fills and the block stalls its request channel.
    // Then the sender stops until every owed beat has come out, and a last burst runs under random receiver stalls.
    task automatic test_output_hold();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_seq <= hold_seq + 1;
        @(posedge i_clk);
        send_random_burst(12, 10);
        wait_idle();
        rcv_stall_pct = 30;
        send_random_burst(8, 10);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_slot_count_settings();
        test_random_phases();
        test_output_hold();
        wait_idle();

        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
